[rtl/dlt_pkg.sv]
package dlt_pkg;

  // Result event codes
  localparam logic [2:0] EV_BYTE  = 3'd0;
  localparam logic [2:0] EV_CLOSE = 3'd1;
  localparam logic [2:0] EV_DROP  = 3'd2;
  localparam logic [2:0] EV_DONE  = 3'd3;
  localparam logic [2:0] EV_ERR   = 3'd4;

  // Error codes
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_STR  = 2'd1;
  localparam logic [1:0] ERR_CHR  = 2'd2;
  localparam logic [1:0] ERR_NUM  = 2'd3;

  // Character constants
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  localparam int unsigned MaxRes = 3;

  typedef enum logic [5:0] {
    M_NORMAL = 6'b000001,
    M_STR    = 6'b000010,
    M_CHR    = 6'b000100,
    M_SIGN   = 6'b001000,
    M_INT    = 6'b010000,
    M_ERR    = 6'b100000
  } mode_t;

  typedef struct packed {
    logic [2:0] ev;
    logic [7:0] tok;
    logic [1:0] err;
  } res_t;

  // All results caused by one input byte, oldest in res[0]
  typedef struct packed {
    logic [1:0]             cnt;
    res_t [MaxRes-1:0]      res;
  } grp_t;

  function automatic grp_t push(grp_t g, logic [2:0] ev, logic [7:0] b, logic [1:0] e);
    grp_t r;
    r = g;
    if (g.cnt != 2'd3) begin
      r.res[g.cnt] = '{ev: ev, tok: b, err: e};
      r.cnt = g.cnt + 2'd1;
    end
    return r;
  endfunction

endpackage

[rtl/dict_literal_tokenizer.sv]
// Dictionary-literal lexer, one text byte per transaction in, one result per transaction out.
// The first result of a byte is offered from the result register, which loads the byte's results
//   from the input register once the output side can take them.
// Throughput: one byte per cycle while out_stall is low and each byte gives at most one result;
//   a byte that gives two or three results holds the input until its last result is taken.
// Reset (rst, synchronous, active high): lexer returns to between-tokens, no word open,
//   output empty.
module dict_literal_tokenizer import dlt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] char_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] event_res,
  output logic [7:0] tok_byte,
  output logic [1:0] err_code,
  output logic       last_of_run
);

  // Input register: one byte waiting for the lexer.
  logic       in_q_valid;
  logic [7:0] in_q;

  // Results the held byte produces, from the lexer decode.
  grp_t grp;
  logic emit_ready;
  logic adv;

  // Advance when the byte has no results, or the output side can take its group.
  assign adv = in_q_valid && ((grp.cnt == 2'd0) || emit_ready);
  assign in_stall = in_q_valid && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_q <= char_in;
    end
  end

  // Lexer state and per-byte decode.
  dlt_lex u_lex (
    .clk (clk),
    .rst (rst),
    .adv (adv),
    .c   (in_q),
    .grp (grp)
  );

  // Result register: hands out the group one result per transaction.
  dlt_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .load        (adv && (grp.cnt != 2'd0)),
    .grp_in      (grp),
    .ready       (emit_ready),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .event_res   (event_res),
    .tok_byte    (tok_byte),
    .err_code    (err_code),
    .last_of_run (last_of_run)
  );

endmodule

[rtl/dlt_lex.sv]
module dlt_lex import dlt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       adv,
  input  logic [7:0] c,
  output grp_t       grp
);

  mode_t mode, mode_next;
  logic  word_open, word_open_next;
  logic  sign_seen, sign_seen_next;

  always_comb begin
    logic       norm;
    logic       digit;
    logic       space;
    logic       ends;
    logic [7:0] quote;
    logic [1:0] code;
    grp_t       g;

    g = '0;
    norm = 1'b0;
    mode_next = mode;
    word_open_next = word_open;
    sign_seen_next = sign_seen;
    digit = (c >= CH_ZERO) && (c <= CH_NINE);
    space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    ends = (c == CH_SPACE) || (c == CH_COLON) || (c == CH_COMMA) ||
           (c == CH_RBRACE) || (c == CH_RBRACK);
    quote = (mode == M_STR) ? CH_DQUOTE : CH_SQUOTE;
    code = (mode == M_STR) ? ERR_STR : ERR_CHR;

    unique case (mode) inside
      M_STR, M_CHR: begin
        if (c == CH_NUL) begin
          g = push(g, EV_ERR, 8'h00, code);
          mode_next = M_NORMAL;
          word_open_next = 1'b0;
          sign_seen_next = 1'b0;
        end else if (c == quote) begin
          g = push(g, EV_CLOSE, 8'h00, ERR_NONE);
          g = push(g, EV_BYTE, c, ERR_NONE);
          g = push(g, EV_CLOSE, 8'h00, ERR_NONE);
          mode_next = M_NORMAL;
        end else begin
          g = push(g, EV_BYTE, c, ERR_NONE);
        end
      end
      M_SIGN, M_INT: begin
        if ((mode == M_SIGN) && (c == (sign_seen ? CH_MINUS : CH_PLUS))) begin
          // hold: repeated sign collapses
        end else if (digit) begin
          g = push(g, EV_BYTE, c, ERR_NONE);
          mode_next = M_INT;
        end else if (ends && !((mode == M_SIGN) && (c == CH_SPACE))) begin
          g = push(g, EV_CLOSE, 8'h00, ERR_NONE);
          mode_next = M_NORMAL;
          norm = 1'b1;
        end else begin
          g = push(g, EV_ERR, 8'h00, ERR_NUM);
          if (c == CH_NUL) begin
            mode_next = M_NORMAL;
            word_open_next = 1'b0;
            sign_seen_next = 1'b0;
          end else begin
            mode_next = M_ERR;
          end
        end
      end
      M_ERR: begin
        if (c == CH_NUL) begin
          mode_next = M_NORMAL;
          word_open_next = 1'b0;
          sign_seen_next = 1'b0;
        end
      end
      default: begin
        mode_next = M_NORMAL;
        norm = 1'b1;
      end
    endcase

    if (norm) begin
      if (c == CH_NUL) begin
        if (word_open) g = push(g, EV_DROP, 8'h00, ERR_NONE);
        g = push(g, EV_DONE, 8'h00, ERR_NONE);
        mode_next = M_NORMAL;
        word_open_next = 1'b0;
        sign_seen_next = 1'b0;
      end else if (space) begin
        // drop whitespace
      end else if ((c == CH_DQUOTE) || (c == CH_SQUOTE) || (c == CH_COLON) ||
                   (c == CH_LBRACE) || (c == CH_RBRACE) || (c == CH_LBRACK) ||
                   (c == CH_RBRACK) || (c == CH_COMMA) || (c == CH_PLUS) ||
                   (c == CH_MINUS) || digit) begin
        if (word_open) g = push(g, EV_CLOSE, 8'h00, ERR_NONE);
        word_open_next = 1'b0;
        if (c != CH_COMMA) g = push(g, EV_BYTE, c, ERR_NONE);
        if ((c == CH_DQUOTE) || (c == CH_SQUOTE) || (c == CH_COLON) ||
            (c == CH_LBRACE) || (c == CH_RBRACE) || (c == CH_LBRACK) ||
            (c == CH_RBRACK)) begin
          g = push(g, EV_CLOSE, 8'h00, ERR_NONE);
        end
        if (c == CH_DQUOTE) mode_next = M_STR;
        if (c == CH_SQUOTE) mode_next = M_CHR;
        if ((c == CH_PLUS) || (c == CH_MINUS)) begin
          mode_next = M_SIGN;
          sign_seen_next = (c == CH_MINUS);
        end
        if (digit) mode_next = M_INT;
      end else begin
        word_open_next = 1'b1;
        g = push(g, EV_BYTE, c, ERR_NONE);
      end
    end

    grp = g;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_NORMAL;
      word_open <= 1'b0;
      sign_seen <= 1'b0;
    end else if (adv) begin
      mode <= mode_next;
      word_open <= word_open_next;
      sign_seen <= sign_seen_next;
    end
  end

endmodule

[rtl/dlt_emit.sv]
module dlt_emit import dlt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  grp_t       grp_in,
  output logic       ready,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] event_res,
  output logic [7:0] tok_byte,
  output logic [1:0] err_code,
  output logic       last_of_run
);

  grp_t       grp;
  logic       full;
  logic [1:0] idx;
  logic       last;
  res_t       cur;

  assign cur = grp.res[idx];
  assign last = (idx == (grp.cnt - 2'd1));
  assign ready = !full || (!out_stall && last);

  assign out_valid = full;
  assign event_res = cur.ev;
  assign tok_byte = cur.tok;
  assign err_code = cur.err;
  assign last_of_run = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
      idx <= 2'd0;
    end else if (load) begin
      full <= 1'b1;
      idx <= 2'd0;
    end else if (full && !out_stall) begin
      if (last) begin
        full <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp <= grp_in;
    end
  end

endmodule

[rtl/dlt_checker.sv]
module dlt_checker import dlt_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] char_in,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] event_res,
  input logic [7:0] tok_byte,
  input logic [1:0] err_code,
  input logic       last_of_run
);

  // Hold a stalled input byte.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(char_in))
    else $error("stalled input changed");

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(event_res) && $stable(tok_byte) &&
      $stable(err_code) && $stable(last_of_run))
    else $error("stalled result changed");

  // Reset empties the output.
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // Only token bytes carry a byte; only errors carry a code.
  a_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((event_res == EV_BYTE) || (tok_byte == 8'h00)) &&
      ((event_res == EV_ERR) == (err_code != ERR_NONE)))
    else $error("field inconsistent with event");

  // Done and error always close the results of their byte.
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((event_res == EV_DONE) || (event_res == EV_ERR)) |-> last_of_run)
    else $error("done or error not last of run");

endmodule

bind dict_literal_tokenizer dlt_checker u_chk (.*);
